// ----- hw/rtl/xrs_pkg.sv -----
// xrs_pkg: shared types, constants and helper functions of the xoshiro128** random source.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package xrs_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [3:0] words_t;

    // Request codes carried in the low bits of the input transfer
    typedef enum logic [2:0] {
        REQ_RAW     = 3'd0,
        REQ_NONNEG  = 3'd1,
        REQ_BOUNDED = 3'd2,
        REQ_SEED32  = 3'd3,
        REQ_SEED64  = 3'd4
    } req_t;

    // Output register source select
    typedef enum logic [1:0] {
        OSEL_RAW,
        OSEL_NONNEG,
        OSEL_MOD,
        OSEL_ZERO
    } osel_t;

    // Input transfer layout
    localparam int REQ_W   = 3;
    localparam int BOUND_W = 32;
    localparam int SEED_W  = 64;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 32;

    // SplitMix64 constants
    localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MIX1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MIX2  = 64'h94D0_49BB_1331_11EB;

    // 32-bit seed chain constants
    localparam word_t SEED_K1 = 32'h9E37_79B9;
    localparam word_t SEED_K2 = 32'h85EB_CA6B;
    localparam word_t SEED_K3 = 32'hC2B2_AE35;

    // Controller to datapath commands
    typedef struct packed {
        logic  load_req;
        logic  seed32;
        logic  step;
        logic  floor_start;
        logic  mod_start;
        logic  mix1;
        logic  mix2;
        logic  store;
        logic  fix;
        logic  out_load;
        osel_t osel;
    } xrs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic reject;
        logic bound_small;
        logic idx_last;
    } xrs_sts_t;

    // Words loaded by a 32-bit seed; zero seed taken as one
    function automatic words_t seed32_load(input word_t seed);
        words_t w;
        w[0] = (seed == 32'd0) ? 32'd1 : seed;
        w[1] = w[0] ^ SEED_K1;
        w[2] = w[1] ^ SEED_K2;
        w[3] = w[2] ^ SEED_K3;
        return w;
    endfunction

    function automatic word_t rotl32(input word_t v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

// ----- hw/rtl/xrs_div.sv -----
// xrs_div: radix-2 restoring divider, remainder only, one bit per cycle.
// Depends on xrs_pkg.
`timescale 1ns / 1ps

module xrs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  xrs_pkg::word_t      dividend,
    input  xrs_pkg::word_t      divisor,
    output logic                done,
    output xrs_pkg::word_t      remainder
);
    import xrs_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    word_t       rem_reg, rem_next;
    word_t       quo_reg, quo_next;
    word_t       dvs_reg, dvs_next;
    logic [32:0] partial;
    logic [32:0] trial;

    assign partial = {rem_reg, quo_reg[31]};
    assign trial   = partial - {1'b0, dvs_reg};

    // One shift-subtract step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = trial[32] ? partial[31:0] : trial[31:0];
            quo_next = {quo_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/xrs_mul.sv -----
// xrs_mul: low 64 bits of a 64x64 product from three 32x32 partial products.
// Depends on xrs_pkg.
`timescale 1ns / 1ps

module xrs_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [63:0]  product
);
    import xrs_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [1:0]  ph_reg, ph_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    word_t       mx, my;
    logic [63:0] pp;

    // Partial product select: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        unique case (ph_reg)
            2'd0:    begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            2'd1:    begin mx = a_reg[31:0];  my = b_reg[63:32]; end
            default: begin mx = a_reg[63:32]; my = b_reg[31:0];  end
        endcase
    end

    assign pp = 64'(mx * my);

    // Accumulate, cross terms into the upper half only
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ph_next   = ph_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            ph_next   = 2'd0;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            if (ph_reg == 2'd0)
                acc_next = pp;
            else
                acc_next = {acc_reg[63:32] + pp[31:0], acc_reg[31:0]};
            ph_next = ph_reg + 2'd1;
            if (ph_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ph_reg   <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hw/rtl/xrs_datapath.sv -----
// xrs_datapath: generator words, request operands, seeding mix, divider and multiplier.
// Depends on xrs_pkg, xrs_div and xrs_mul.
`timescale 1ns / 1ps

module xrs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  xrs_pkg::xrs_cmd_t   cmd,
    input  xrs_pkg::word_t      bound_in,
    input  logic [63:0]         seed_in,
    output xrs_pkg::xrs_sts_t   sts,
    output xrs_pkg::word_t      result
);
    import xrs_pkg::*;

    words_t      words_reg, words_next;
    word_t       bound_reg;
    logic [63:0] seed_reg;
    word_t       draw_reg;
    word_t       result_reg;
    logic [1:0]  idx_reg, idx_next;

    word_t       gen_out;
    words_t      gen_adv;
    word_t       n0, n1, n2, n3, t;
    word_t       x5;

    logic        div_start, div_done;
    word_t       div_dividend, div_rem;
    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;
    logic [63:0] seed_inc;
    logic [63:0] mix2_a;
    logic [63:0] fin;

    // xoshiro128** output and state advance
    always_comb
    begin
        x5      = (words_reg[1] << 2) + words_reg[1];
        gen_out = (rotl32(x5, 7) << 3) + rotl32(x5, 7);
        t       = words_reg[1] << 9;
        n2      = words_reg[2] ^ words_reg[0];
        n3      = words_reg[3] ^ words_reg[1];
        n1      = words_reg[1] ^ n2;
        n0      = words_reg[0] ^ n3;
        gen_adv[0] = n0;
        gen_adv[1] = n1;
        gen_adv[2] = n2 ^ t;
        gen_adv[3] = rotl32(n3, 11);
    end

    // SplitMix64 operands
    assign seed_inc = seed_reg + SM_GAMMA;
    assign mix2_a   = mul_p ^ (mul_p >> 27);
    assign fin      = mul_p ^ (mul_p >> 31);

    assign mul_start = cmd.mix1 | cmd.mix2;
    assign mul_a     = cmd.mix1 ? (seed_inc ^ (seed_inc >> 30)) : mix2_a;
    assign mul_b     = cmd.mix1 ? SM_MIX1 : SM_MIX2;

    // Floor is (2^32 - bound) mod bound; remainder holds until the next start
    assign div_start    = cmd.floor_start | cmd.mod_start;
    assign div_dividend = cmd.floor_start ? (32'd0 - bound_reg) : draw_reg;

    xrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    xrs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Generator word updates
    always_comb
    begin
        words_next = words_reg;
        idx_next   = idx_reg;
        if (cmd.load_req)
            idx_next = 2'd0;
        if (cmd.seed32)
            words_next = seed32_load(seed_reg[31:0]);
        if (cmd.step)
            words_next = gen_adv;
        if (cmd.store)
        begin
            words_next[idx_reg] = fin[63:32];
            idx_next            = idx_reg + 2'd1;
        end
        if (cmd.fix && (words_reg == '0))
            words_next[0] = 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= seed32_load(32'd1);
            idx_reg   <= 2'd0;
        end
        else
        begin
            words_reg <= words_next;
            idx_reg   <= idx_next;
        end
    end

    // Operand, draw and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            bound_reg <= bound_in;
            seed_reg  <= seed_in;
        end
        else if (cmd.mix1)
            seed_reg <= seed_inc;
        if (cmd.step)
            draw_reg <= gen_out;
        if (cmd.out_load)
        begin
            unique case (cmd.osel)
                OSEL_RAW:    result_reg <= draw_reg;
                OSEL_NONNEG: result_reg <= draw_reg >> 1;
                OSEL_MOD:    result_reg <= div_rem;
                OSEL_ZERO:   result_reg <= '0;
            endcase
        end
    end

    assign sts.div_done    = div_done;
    assign sts.mul_done    = mul_done;
    assign sts.reject      = (draw_reg < div_rem);
    assign sts.bound_small = (bound_reg < 32'd2);
    assign sts.idx_last    = (idx_reg == 2'd3);
    assign result          = result_reg;

endmodule

// ----- hw/rtl/xrs_ctrl.sv -----
// xrs_ctrl: request sequencer and output register valid for the random source.
// Depends on xrs_pkg.
`timescale 1ns / 1ps

module xrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          req_type,
    output logic                m_tvalid,
    input  logic                m_tready,
    output xrs_pkg::xrs_cmd_t   cmd,
    input  xrs_pkg::xrs_sts_t   sts
);
    import xrs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED32,
        ST_DRAW,
        ST_BND_CHK,
        ST_FLOOR_START,
        ST_FLOOR_WAIT,
        ST_REJ_CHK,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_RESULT,
        ST_S64_MIX1,
        ST_S64_WAIT1,
        ST_S64_MIX2,
        ST_S64_WAIT2,
        ST_S64_STORE,
        ST_S64_FIX
    } state_t;

    state_t state_reg, state_next;
    req_t   kind_reg, kind_next;
    logic   ovalid_reg, ovalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign out_free = !ovalid_reg || m_tready;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.osel   = OSEL_RAW;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    kind_next    = req_t'(req_type);
                    unique case (req_t'(req_type))
                        REQ_RAW, REQ_NONNEG: state_next = ST_DRAW;
                        REQ_BOUNDED:         state_next = ST_BND_CHK;
                        REQ_SEED32:          state_next = ST_SEED32;
                        REQ_SEED64:          state_next = ST_S64_MIX1;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEED32:
            begin
                cmd.seed32 = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DRAW:
            begin
                cmd.step   = 1'b1;
                state_next = (kind_reg == REQ_BOUNDED) ? ST_REJ_CHK : ST_RESULT;
            end
            ST_BND_CHK:
                state_next = sts.bound_small ? ST_RESULT : ST_FLOOR_START;
            ST_FLOOR_START:
            begin
                cmd.floor_start = 1'b1;
                state_next      = ST_FLOOR_WAIT;
            end
            ST_FLOOR_WAIT:
                if (sts.div_done)
                    state_next = ST_DRAW;
            ST_REJ_CHK:
                state_next = sts.reject ? ST_DRAW : ST_MOD_START;
            ST_MOD_START:
            begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
                if (sts.div_done)
                    state_next = ST_RESULT;
            ST_RESULT:
            begin
                priority if (kind_reg == REQ_NONNEG)
                    cmd.osel = OSEL_NONNEG;
                else if (kind_reg == REQ_BOUNDED)
                    cmd.osel = sts.bound_small ? OSEL_ZERO : OSEL_MOD;
                else
                    cmd.osel = OSEL_RAW;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_S64_MIX1:
            begin
                cmd.mix1   = 1'b1;
                state_next = ST_S64_WAIT1;
            end
            ST_S64_WAIT1:
                if (sts.mul_done)
                    state_next = ST_S64_MIX2;
            ST_S64_MIX2:
            begin
                cmd.mix2   = 1'b1;
                state_next = ST_S64_WAIT2;
            end
            ST_S64_WAIT2:
                if (sts.mul_done)
                    state_next = ST_S64_STORE;
            ST_S64_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = sts.idx_last ? ST_S64_FIX : ST_S64_MIX1;
            end
            ST_S64_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_IDLE;
            end
        endcase

        // Output register valid
        if (cmd.out_load)
            ovalid_next = 1'b1;
        else if (m_tready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            kind_reg   <= REQ_RAW;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ----- hw/rtl/xoshiro128ss_random_source.sv -----
// xoshiro128ss_random_source: top level, joins the request sequencer and the datapath.
// Depends on xrs_pkg, xrs_ctrl and xrs_datapath.
//
//   channel | direction | contents
//   s_*     | in        | request: req_type, bound, seed_value
//   m_*     | out       | random_value, one per draw request
//
// Raw and non-negative draws: m_tvalid and s_tready rise together, after ST_DRAW and ST_RESULT.
// Bounded draws: m_tvalid follows a floor pass and a mod pass, each a start and its steps, on
// the shared bit-serial divider, with a fresh draw for each rejected one; a bound below 2
// skips the divider and returns zero.
// A 64-bit reseed keeps s_tready low through two three-phase 64-bit multiplies and a store
// per word, then the all-zero fix; a 32-bit reseed takes the single ST_SEED32 state.
// Reset loads the words as for a 32-bit seed of 1; no clearing pass is needed.
// One request is in work at a time; a draw that finds a result still held waits in
// its last state until the output register frees, and the input stays closed meanwhile.
`timescale 1ns / 1ps

module xoshiro128ss_random_source (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // [2:0] req_type, [34:3] bound, [98:35] seed_value
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata    // [31:0] random_value
);
    import xrs_pkg::*;

    xrs_cmd_t cmd;
    xrs_sts_t sts;

    xrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tdata[REQ_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    xrs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .bound_in (s_tdata[REQ_W+BOUND_W-1:REQ_W]),
        .seed_in  (s_tdata[REQ_W+BOUND_W+SEED_W-1:REQ_W+BOUND_W]),
        .sts      (sts),
        .result   (m_tdata)
    );

endmodule

// ----- hw/rtl/xrs_checker.sv -----
// xrs_checker: port-level checks on the random source, bound to the top level.
// Depends on xrs_pkg and the xoshiro128ss_random_source port names.
`timescale 1ns / 1ps

module xrs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [103:0]  s_tdata,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [31:0]   m_tdata
);
    import xrs_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A raw draw transfer closes the input while it is worked on
    a_raw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[REQ_W-1:0] == REQ_RAW) |=> !s_tready)
        else $error("input open right after raw draw");

    // A new result only appears after the input was closed for work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

endmodule

bind xoshiro128ss_random_source xrs_checker u_xrs_checker (.*);
